FILE: rtl/isort_pkg.sv
// shared types and constants for the insertion sorter
package isort_pkg;

  localparam int unsigned CAPACITY = 64;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_final;
  } req_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_set;
    logic               dropped;
  } res_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic signed [31:0] value;
    logic               full;
    logic               gt;
  } link_t;

  // per-cycle command broadcast along the chain
  typedef struct packed {
    logic insert;
    logic unload;
  } cell_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

endpackage

FILE: rtl/isort_cell.sv
// one entry of the sorting chain: holds a value and compares it with the incoming one
module isort_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  isort_pkg::cell_ctrl_t     ctrl_i,
  input  logic signed [31:0]        new_value_i,
  input  isort_pkg::link_t          left_i,
  input  isort_pkg::link_t          right_i,
  output isort_pkg::link_t          link_o
);

  logic signed [31:0] value_q, value_d;
  logic               full_q, full_d;
  logic               gt;
  logic               take_left;
  logic               take_new;

  // equal values stay in front of the new one, keeping the order stable
  assign gt        = full_q && (value_q > new_value_i);
  assign take_left = left_i.gt;
  assign take_new  = !take_left && (gt || (!full_q && left_i.full));

  always_comb begin
    value_d = value_q;
    full_d  = full_q;
    if (ctrl_i.unload) begin
      value_d = right_i.value;
      full_d  = right_i.full;
    end else if (ctrl_i.insert) begin
      if (take_left) begin
        value_d = left_i.value;
        full_d  = 1'b1;
      end else if (take_new) begin
        value_d = new_value_i;
        full_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.value = value_q;
  assign link_o.full  = full_q;
  assign link_o.gt    = gt;

endmodule

FILE: rtl/insertion_sorter_core.sv
// top level of the insertion sorter: cell chain and fill/drain control
//
// Usage: present a request on req_i with start high; it is taken at a rising
// edge where start is high and busy is low. Each value is placed into a row
// of CAPACITY cells that keep the stored values in ascending order; a value
// equal to a stored one lands after it. Every cell compares the broadcast
// value with its own and keeps its value or takes its left neighbor's value
// or the new one, so after a non-final request a new request can follow in
// the next cycle.
// A request with is_final set is inserted, then the block raises busy and
// streams the set out of the first cell, one result per cycle on res_o with
// result_valid_o high, while the chain shifts toward it. The first result
// appears in the cycle after the final request; every stored value of the set
// is shown once, and busy falls after the result marked end_of_set.
// Values arriving while all cells are full are dropped; every result of that
// set then carries dropped. The receiver cannot stall: each result is shown
// for exactly one cycle. Reset empties all cells and clears the drop flag.
module insertion_sorter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  isort_pkg::req_t   req_i,
  output logic              result_valid_o,
  output isort_pkg::res_t   res_o
);

  localparam int unsigned N = isort_pkg::CAPACITY;

  isort_pkg::state_e     state_q, state_d;
  logic                  lost_q, lost_d;
  logic                  accept;
  logic                  store_full;
  logic                  last_out;
  isort_pkg::cell_ctrl_t ctrl;
  isort_pkg::link_t      links [N];
  isort_pkg::link_t      left_of [N];
  isort_pkg::link_t      right_of [N];

  assign accept     = start && (state_q == isort_pkg::ST_FILL);
  assign store_full = links[N-1].full;
  assign last_out   = !links[1].full;

  assign ctrl.insert = accept && !store_full;
  assign ctrl.unload = (state_q == isort_pkg::ST_DRAIN);

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_head
        // the head sees a full, never-greater neighbor
        assign left_of[i] = '{value: '0, full: 1'b1, gt: 1'b0};
      end else begin : g_mid
        assign left_of[i] = links[i-1];
      end
      if (i == N - 1) begin : g_tail
        assign right_of[i] = '{value: '0, full: 1'b0, gt: 1'b0};
      end else begin : g_body
        assign right_of[i] = links[i+1];
      end
      isort_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .new_value_i (req_i.value),
        .left_i      (left_of[i]),
        .right_i     (right_of[i]),
        .link_o      (links[i])
      );
    end
  endgenerate

  always_comb begin
    state_d = state_q;
    case (state_q)
      isort_pkg::ST_FILL: begin
        if (accept && req_i.is_final) begin
          state_d = isort_pkg::ST_DRAIN;
        end
      end
      isort_pkg::ST_DRAIN: begin
        if (last_out) begin
          state_d = isort_pkg::ST_FILL;
        end
      end
      default: state_d = isort_pkg::ST_FILL;
    endcase
  end

  always_comb begin
    lost_d = lost_q;
    case (state_q)
      isort_pkg::ST_FILL: begin
        if (accept && store_full) begin
          lost_d = 1'b1;
        end
      end
      isort_pkg::ST_DRAIN: begin
        if (last_out) begin
          lost_d = 1'b0;
        end
      end
      default: lost_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isort_pkg::ST_FILL;
      lost_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lost_q  <= lost_d;
    end
  end

  assign busy                = (state_q == isort_pkg::ST_DRAIN);
  assign result_valid_o      = (state_q == isort_pkg::ST_DRAIN);
  assign res_o.sorted_value  = links[0].value;
  assign res_o.end_of_set    = last_out;
  assign res_o.dropped       = lost_q;

endmodule

FILE: rtl/isort_checker.sv
// port-level checks for the insertion sorter, bound to the top level
module isort_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input isort_pkg::req_t req_i,
  input logic            result_valid_o,
  input isort_pkg::res_t res_o
);

  // a final request starts the unload in the next cycle
  a_final_unloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.is_final |=> busy && result_valid_o)
    else $error("final request did not start unload");

  // a plain request produces no result
  a_plain_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !req_i.is_final |=> !result_valid_o)
    else $error("result after a non-final request");

  // results of one set come back to back until end of set
  a_stream_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !res_o.end_of_set |=> result_valid_o && $stable(res_o.dropped))
    else $error("gap or drop flag change inside a set");

  // the block frees up right after the last result
  a_end_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.end_of_set |=> !busy && !result_valid_o)
    else $error("still busy after end of set");

endmodule

bind insertion_sorter_core isort_checker u_isort_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_i          (req_i),
  .result_valid_o (result_valid_o),
  .res_o          (res_o)
);

FILE: bench/tb_insertion_sorter_core.sv
// self-checking testbench for insertion_sorter_core: directed sets, then random sets
module tb_insertion_sorter_core;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_SETTLE   = 8;
  localparam int unsigned N_DIRECTED     = 21;

  typedef struct {
    isort_pkg::req_t req;
    bit              known;
    isort_pkg::res_t known_res;
  } dir_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  isort_pkg::req_t req;
  logic            result_valid_o;
  isort_pkg::res_t res_o;

  insertion_sorter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // model of the sorted store
  logic signed [31:0] held_val [isort_pkg::CAPACITY];
  int unsigned        held_cnt;
  bit                 held_lost;
  isort_pkg::res_t    pending_sorted [$];

  int unsigned     mismatches;
  int unsigned     reqs_sent;
  int unsigned     sets_done;
  int unsigned     lossy_sets;
  int unsigned     results_seen;
  int unsigned     idle_cycles;
  int unsigned     burst_left;
  bit              calm;
  isort_pkg::res_t sorted_exp;

  task automatic predict_sorted(isort_pkg::req_t r, bit known, isort_pkg::res_t known_res);
    int unsigned     pos;
    isort_pkg::res_t e;
    if (held_cnt >= isort_pkg::CAPACITY) begin
      held_lost = 1'b1;
    end else begin
      // larger values move up, equal ones stay ahead
      pos = held_cnt;
      while (pos > 0 && $signed(held_val[pos-1]) > $signed(r.value)) begin
        held_val[pos] = held_val[pos-1];
        pos--;
      end
      held_val[pos] = r.value;
      held_cnt++;
    end
    if (r.is_final) begin
      if (known) begin
        pending_sorted.push_back(known_res);
      end else begin
        for (int unsigned k = 0; k < held_cnt; k++) begin
          e.sorted_value = held_val[k];
          e.end_of_set   = (k + 1 == held_cnt);
          e.dropped      = held_lost;
          pending_sorted.push_back(e);
        end
      end
      sets_done++;
      if (held_lost) lossy_sets++;
      held_cnt  = 0;
      held_lost = 1'b0;
    end
  endtask

  task automatic send_request(isort_pkg::req_t r, bit known, isort_pkg::res_t known_res);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    predict_sorted(r, known, known_res);
    reqs_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       pick_value = 32'sh8000_0000;
      1:       pick_value = 32'sh7fff_ffff;
      2, 3:    pick_value = $signed($urandom_range(0, 8)) - 32'sd4;
      default: pick_value = $signed($urandom);
    endcase
  endfunction

  task automatic send_set(int unsigned n);
    isort_pkg::req_t r;
    for (int unsigned i = 0; i < n; i++) begin
      r.value    = pick_value();
      r.is_final = (i + 1 == n);
      send_request(r, 1'b0, '0);
    end
  endtask

  // results cannot be held off, so every strobe is checked right away
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_sorted.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d end %0b dropped %0b",
                   res_o.sorted_value, res_o.end_of_set, res_o.dropped);
      end else begin
        sorted_exp = pending_sorted.pop_front();
        if (res_o.sorted_value !== sorted_exp.sorted_value ||
            res_o.end_of_set !== sorted_exp.end_of_set ||
            res_o.dropped !== sorted_exp.dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                     sorted_exp.sorted_value, sorted_exp.end_of_set, sorted_exp.dropped,
                     res_o.sorted_value, res_o.end_of_set, res_o.dropped);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t dir_tab [N_DIRECTED];
    start      <= 1'b0;
    req        <= '0;
    rst_ni     <= 1'b0;
    held_cnt   = 0;
    held_lost  = 1'b0;
    burst_left = 0;
    calm       = 1'b0;
    dir_tab = '{
      // single-value sets: the value comes straight back, flagged as end of set
      '{'{32'sd0, 1'b1},            1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{'{32'sh7fff_ffff, 1'b1},    1'b1, '{32'sh7fff_ffff, 1'b1, 1'b0}},
      '{'{32'sh8000_0000, 1'b1},    1'b1, '{32'sh8000_0000, 1'b1, 1'b0}},
      '{'{-32'sd1, 1'b1},           1'b1, '{-32'sd1, 1'b1, 1'b0}},
      // mixed set with extremes, duplicates and alternating bit patterns
      '{'{32'sd5, 1'b0},            1'b0, '0},
      '{'{32'sd3, 1'b0},            1'b0, '0},
      '{'{32'sd5, 1'b0},            1'b0, '0},
      '{'{32'sh7fff_ffff, 1'b0},    1'b0, '0},
      '{'{32'sh8000_0000, 1'b0},    1'b0, '0},
      '{'{-32'sd1, 1'b0},           1'b0, '0},
      '{'{32'sd0, 1'b0},            1'b0, '0},
      '{'{32'sd1, 1'b0},            1'b0, '0},
      '{'{32'sh5555_5555, 1'b0},    1'b0, '0},
      '{'{32'shaaaa_aaaa, 1'b0},    1'b0, '0},
      '{'{32'sd3, 1'b0},            1'b0, '0},
      '{'{-32'sd7, 1'b1},           1'b0, '0},
      // descending set, every insertion goes to the front
      '{'{32'sd4, 1'b0},            1'b0, '0},
      '{'{32'sd3, 1'b0},            1'b0, '0},
      '{'{32'sd2, 1'b0},            1'b0, '0},
      '{'{32'sd1, 1'b0},            1'b0, '0},
      '{'{32'sd0, 1'b1},            1'b0, '0}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_request(dir_tab[i].req, dir_tab[i].known, dir_tab[i].known_res);

    // random small sets, some of them sent back to back
    while (reqs_sent < N_DIRECTED + 20) begin
      calm = ($urandom_range(0, 3) == 0);
      send_set($urandom_range(1, 10));
    end
    calm = 1'b0;
    // store filled up, then one value too many with the final one dropped
    send_set(isort_pkg::CAPACITY + 1);
    // sets after an overflow must come out clean
    repeat (3) send_set($urandom_range(1, 6));
    start <= 1'b0;

    while (pending_sorted.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SETTLE) @(posedge clk_i);

    $display("sent %0d requests in %0d sets (%0d with dropped values), checked %0d results",
             reqs_sent, sets_done, lossy_sets, results_seen);
    $display("%0d mismatches, %0d results still outstanding",
             mismatches, pending_sorted.size());
    if (mismatches == 0 && pending_sorted.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
